// ----- sv/send_history_table_assert.svh -----
// Assertion macros for the send history table.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef SEND_HISTORY_TABLE_ASSERT_SVH
`define SEND_HISTORY_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SHT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SHT_ASSERT(lbl, prop, msg)
`define SHT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/sht_pkg.sv -----
// Shared types and constants of the send history table.
// No dependencies; used by the controller, the datapath and the top level.
package sht_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam logic [31:0] LimitReset   = 32'd60000;

  localparam logic OpAdd = 1'b0;
  localparam logic OpGet = 1'b1;

  typedef struct packed {
    logic        vld;
    logic [15:0] seq;
    logic [31:0] cts;
    logic [31:0] sts;
    logic [15:0] bytes;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic mod_step;
    logic cnt_clr;
    logic cnt_inc;
    logic min_proc;
    logic sub_proc;
    logic evict;
    logic store;
    logic look_rd;
    logic look_done;
  } cmd_t;

  typedef struct packed {
    logic clr_end;
    logic mod_end;
    logic scan_end;
    logic expire;
    logic is_get;
    logic out_valid;
  } status_t;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_MOD   = 8'b00000100,
    S_MIN   = 8'b00001000,
    S_EVAL  = 8'b00010000,
    S_SUB   = 8'b00100000,
    S_LOOK  = 8'b01000000,
    S_LOOKD = 8'b10000000
  } state_e;

endpackage

// ----- sv/sht_ctrl.sv -----
// Controller state machine of the send history table.
// Depends on sht_pkg; drives datapath commands from datapath status.
module sht_ctrl import sht_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   ready;

  assign ready      = (state_q == S_IDLE) && !status_i.out_valid;
  assign in_stall_o = !ready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.clr_end) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && ready) begin
          cmd_o.accept = 1'b1;
          state_d      = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_end) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = status_i.is_get ? S_SUB : S_MIN;
        end
      end
      S_MIN: begin
        cmd_o.min_proc = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (status_i.scan_end) state_d = S_EVAL;
      end
      S_EVAL: begin
        // Evict the oldest entry and search again, or store the new one.
        if (status_i.expire) begin
          cmd_o.evict   = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_MIN;
        end else begin
          cmd_o.store = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SUB: begin
        cmd_o.sub_proc = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (status_i.scan_end) state_d = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.look_rd = 1'b1;
        state_d       = S_LOOKD;
      end
      S_LOOKD: begin
        cmd_o.look_done = 1'b1;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/sht_dp.sv -----
// Datapath of the send history table: slot memory, scan counter, byte total,
// acknowledgement mark, slot index unit and result registers. Depends on sht_pkg.
module sht_dp import sht_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        opcode_i,
  input  logic [15:0] seq_num_i,
  input  logic [31:0] create_ts_i,
  input  logic [31:0] send_ts_i,
  input  logic [15:0] payload_size_i,
  input  logic        remove_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [31:0] entry_create_ts_o,
  output logic [31:0] entry_send_ts_o,
  output logic [15:0] entry_payload_size_o,
  output logic [31:0] bytes_in_flight_o,
  output logic [15:0] last_acked_seq_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned RW = 17;
  // Rounded-up reciprocal of DEPTH; exact quotients for any 16-bit sequence.
  localparam logic [28:0] Recip = 29'(((64'd1 << 32) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  entry_t mem [DEPTH];
  entry_t rd_q;

  logic [31:0]   limit_q, total_q, total_d;
  logic [15:0]   ack_q, ack_d;
  logic          op_q, rem_flag_q;
  logic [15:0]   seq_q, size_q;
  logic [31:0]   cts_q, sts_q;
  logic [RW-1:0] rem_q, quo_scaled;
  logic [12:0]   quo_q;
  logic [44:0]   recip_prod;
  logic          mod_cnt_q;
  logic [CW-1:0] cnt_q;
  logic          best_vld_q;
  logic [15:0]   best_seq_q;
  logic [31:0]   best_cts_q;
  logic [15:0]   best_bytes_q;
  logic [AW-1:0] best_slot_q;
  logic [AW-1:0] slot, rd_addr, wr_addr, proc_slot;
  logic          wr_en, scan_live, hit;
  entry_t        wr_data;
  logic [32:0]   expire_sum, add_sum;
  logic          out_valid_q;

  assign slot       = rem_q[AW-1:0];
  assign rd_addr    = cmd_i.look_rd ? slot : cnt_q[AW-1:0];
  assign proc_slot  = AW'(cnt_q - CW'(1));
  assign scan_live  = (cnt_q != '0) && rd_q.vld;
  assign hit        = rd_q.vld && (rd_q.seq == seq_q);
  assign recip_prod = {29'd0, seq_q} * {16'd0, Recip};
  assign quo_scaled = {4'd0, quo_q} * RW'(DEPTH);

  assign expire_sum = {1'b0, best_cts_q} + {1'b0, limit_q};
  assign add_sum    = {1'b0, total_q} + {17'd0, size_q};

  assign status_o.clr_end   = (cnt_q == CW'(DEPTH - 1));
  assign status_o.mod_end   = mod_cnt_q;
  assign status_o.scan_end  = (cnt_q == CW'(DEPTH));
  assign status_o.expire    = best_vld_q && (expire_sum < {1'b0, sts_q});
  assign status_o.is_get    = (op_q == OpGet);
  assign status_o.out_valid = out_valid_q;

  // One write per cycle; the sources are exclusive commands (clear, evict, store, remove).
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q[AW-1:0];
    wr_data = '0;
    if (cmd_i.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.evict) begin
      wr_en   = 1'b1;
      wr_addr = best_slot_q;
    end else if (cmd_i.store) begin
      wr_en   = 1'b1;
      wr_addr = slot;
      wr_data = '{vld: 1'b1, seq: seq_q, cts: cts_q, sts: sts_q, bytes: size_q};
    end else if (cmd_i.look_done && hit && rem_flag_q) begin
      wr_en   = 1'b1;
      wr_addr = slot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    total_d = total_q;
    ack_d   = ack_q;
    if (cmd_i.sub_proc && scan_live && (rd_q.seq >= ack_q) && (rd_q.seq < seq_q)) begin
      total_d = (total_q > {16'd0, rd_q.bytes}) ? total_q - {16'd0, rd_q.bytes} : '0;
    end
    if (cmd_i.evict && (best_seq_q > ack_q)) begin
      total_d = (total_q > {16'd0, best_bytes_q}) ? total_q - {16'd0, best_bytes_q} : '0;
      ack_d   = best_seq_q;
    end
    if (cmd_i.store) begin
      total_d = add_sum[32] ? '1 : add_sum[31:0];
      if (ack_q == '0) ack_d = (seq_q == '0) ? '0 : seq_q - 16'd1;
    end
    if (cmd_i.look_done && (seq_q > ack_q)) ack_d = seq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      total_q     <= '0;
      ack_q       <= '0;
      cnt_q       <= '0;
      mod_cnt_q   <= 1'b0;
      best_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      total_q <= total_d;
      ack_q   <= ack_d;
      if (cmd_i.cnt_clr) begin
        cnt_q      <= '0;
        best_vld_q <= 1'b0;
      end else begin
        if (cmd_i.cnt_inc) cnt_q <= cnt_q + CW'(1);
        if (cmd_i.min_proc && scan_live && (!best_vld_q || rd_q.seq < best_seq_q)) begin
          best_vld_q <= 1'b1;
        end
      end
      if (cmd_i.accept) begin
        mod_cnt_q <= 1'b0;
      end else if (cmd_i.mod_step) begin
        mod_cnt_q <= 1'b1;
      end
      if (cmd_i.store || cmd_i.look_done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, slot index, best candidate and result payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= opcode_i;
      seq_q      <= seq_num_i;
      cts_q      <= create_ts_i;
      sts_q      <= send_ts_i;
      size_q     <= payload_size_i;
      rem_flag_q <= remove_i;
      rem_q      <= '0;
    end else if (cmd_i.mod_step) begin
      // Quotient by reciprocal multiplication first, then the remainder.
      if (!mod_cnt_q) begin
        quo_q <= recip_prod[44:32];
      end else begin
        rem_q <= {1'b0, seq_q} - quo_scaled;
      end
    end
    if (cmd_i.min_proc && scan_live && (!best_vld_q || rd_q.seq < best_seq_q)) begin
      best_seq_q   <= rd_q.seq;
      best_cts_q   <= rd_q.cts;
      best_bytes_q <= rd_q.bytes;
      best_slot_q  <= proc_slot;
    end
    if (cmd_i.store) begin
      found_o              <= 1'b1;
      entry_create_ts_o    <= cts_q;
      entry_send_ts_o      <= sts_q;
      entry_payload_size_o <= size_q;
      bytes_in_flight_o    <= total_d;
      last_acked_seq_o     <= ack_d;
    end else if (cmd_i.look_done) begin
      found_o              <= hit;
      entry_create_ts_o    <= hit ? rd_q.cts : '0;
      entry_send_ts_o      <= hit ? rd_q.sts : '0;
      entry_payload_size_o <= hit ? rd_q.bytes : '0;
      bytes_in_flight_o    <= total_q;
      last_acked_seq_o     <= ack_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/send_history_table.sv -----
// Send history table top level. An add walks the slots once, and once more for
// each expired entry evicted; a get walks them once and then reads the item's
// slot. Each walk reads the slot memory once per slot, and one item is in work
// at a time: the next input transfer can be taken at the earliest in the cycle
// after the result transfer. After reset a clearing pass invalidates every slot
// before the first input transfer; config writes go on.
module send_history_table import sht_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] seq_num_i,
  input  logic [31:0] create_ts_i,
  input  logic [31:0] send_ts_i,
  input  logic [15:0] payload_size_i,
  input  logic        remove_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [31:0] entry_create_ts_o,
  output logic [31:0] entry_send_ts_o,
  output logic [15:0] entry_payload_size_o,
  output logic [31:0] bytes_in_flight_o,
  output logic [15:0] last_acked_seq_o
);

  `include "send_history_table_assert.svh"

  cmd_t    cmd;
  status_t status;
  logic    in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  sht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sht_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .opcode_i             (opcode_i),
    .seq_num_i            (seq_num_i),
    .create_ts_i          (create_ts_i),
    .send_ts_i            (send_ts_i),
    .payload_size_i       (payload_size_i),
    .remove_i             (remove_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .found_o              (found_o),
    .entry_create_ts_o    (entry_create_ts_o),
    .entry_send_ts_o      (entry_send_ts_o),
    .entry_payload_size_o (entry_payload_size_o),
    .bytes_in_flight_o    (bytes_in_flight_o),
    .last_acked_seq_o     (last_acked_seq_o)
  );

  `SHT_ASSERT_IMPL(a_accept_no_pending, in_xfer, !out_valid_o, "input taken with result pending")
  `SHT_ASSERT(a_one_in_work, in_xfer |=> in_stall_o, "second item taken while one is in work")
  `SHT_ASSERT(a_result_stalls_input, $rose(out_valid_o) |-> in_stall_o, "result with input open")

endmodule
